>>> rtl/core/plc_pkg.sv
`default_nettype none

package plc_pkg;

  localparam int unsigned TIMER_WIDTH_DEF = 32;
  localparam int unsigned LIMIT_WIDTH     = 32;
  localparam int unsigned CFG_IDX_WIDTH   = 3;
  localparam int unsigned CFG_DATA_WIDTH  = 32;

  typedef enum logic [1:0] {
    MODE_PRESENT  = 2'd0,
    MODE_SCANNING = 2'd1,
    MODE_AWAY     = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_INACTIVE_LIMIT = 3'd0,
    CFG_SCAN_PERIOD    = 3'd1,
    CFG_FAIL_LIMIT     = 3'd2,
    CFG_IDLE_LIMIT     = 3'd3,
    CFG_SHUTTER_LIMIT  = 3'd4
  } cfg_idx_e;

  localparam logic [31:0] INACTIVE_LIMIT_RST = 32'd60000;
  localparam logic [15:0] SCAN_PERIOD_RST    = 16'd2000;
  localparam logic [7:0]  FAIL_LIMIT_RST     = 8'd3;
  localparam logic [31:0] IDLE_LIMIT_RST     = 32'd600000;
  localparam logic [31:0] SHUTTER_LIMIT_RST  = 32'd300000;

  typedef struct packed {
    logic [31:0] inactive_limit_ms;
    logic [15:0] scan_period_ms;
    logic [7:0]  fail_limit;
    logic [31:0] idle_limit_ms;
    logic [31:0] shutter_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic [15:0] elapsed_ms;
    logic        activity_seen;
    logic        face_seen;
    logic        shutter_closed;
  } tick_t;

  typedef struct packed {
    mode_e       presence_mode;
    logic        user_present;
    logic        lock_request;
    logic        camera_release;
    logic [7:0]  failures_so_far;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/plc_cfg.sv
`default_nettype none

module plc_cfg (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [plc_pkg::CFG_IDX_WIDTH-1:0]    cfg_index_i,
  input  wire logic [plc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data_i,
  output plc_pkg::cfg_t                             cfg_o
);
  import plc_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inactive_limit_ms <= INACTIVE_LIMIT_RST;
      cfg_q.scan_period_ms    <= SCAN_PERIOD_RST;
      cfg_q.fail_limit        <= FAIL_LIMIT_RST;
      cfg_q.idle_limit_ms     <= IDLE_LIMIT_RST;
      cfg_q.shutter_limit_ms  <= SHUTTER_LIMIT_RST;
    end else if (cfg_valid_i) begin
      // unknown indexes are dropped
      case (cfg_index_i)
        CFG_INACTIVE_LIMIT: cfg_q.inactive_limit_ms <= cfg_data_i[31:0];
        CFG_SCAN_PERIOD:    cfg_q.scan_period_ms    <= cfg_data_i[15:0];
        CFG_FAIL_LIMIT:     cfg_q.fail_limit        <= cfg_data_i[7:0];
        CFG_IDLE_LIMIT:     cfg_q.idle_limit_ms     <= cfg_data_i[31:0];
        CFG_SHUTTER_LIMIT:  cfg_q.shutter_limit_ms  <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/plc_step.sv
`default_nettype none

module plc_step #(
  parameter int unsigned TimerWidth = plc_pkg::TIMER_WIDTH_DEF
) (
  input  wire plc_pkg::cfg_t       cfg_i,
  input  wire plc_pkg::tick_t      tick_i,
  input  wire plc_pkg::mode_e      mode_i,
  input  wire logic [TimerWidth-1:0] timer_i,
  input  wire logic [7:0]          fail_i,
  input  wire logic [15:0]         closed_i,
  output plc_pkg::mode_e           mode_o,
  output logic [TimerWidth-1:0]    timer_o,
  output logic [7:0]               fail_o,
  output logic [15:0]              closed_o,
  output plc_pkg::result_t         result_o
);
  import plc_pkg::*;

  localparam int unsigned SumW = TimerWidth + 1;
  localparam int unsigned CmpW = (TimerWidth > LIMIT_WIDTH) ? TimerWidth : LIMIT_WIDTH;

  logic [SumW-1:0]       sum;
  logic [TimerWidth-1:0] idle_now;
  logic [CmpW-1:0]       idle_cmp;
  logic                  over_inactive;
  logic                  over_idle;
  logic [15:0]           closed_inc;
  logic [7:0]            fail_inc;
  logic [31:0]           closed_ms;
  logic                  shutter_hit;
  logic                  fail_hit;
  logic                  lock;

  // saturating idle timer
  assign sum      = SumW'(timer_i) + SumW'(tick_i.elapsed_ms);
  assign idle_now = sum[SumW-1] ? {TimerWidth{1'b1}} : sum[TimerWidth-1:0];
  assign idle_cmp = CmpW'(idle_now);

  assign over_inactive = idle_cmp > CmpW'(cfg_i.inactive_limit_ms);
  assign over_idle     = idle_cmp > CmpW'(cfg_i.idle_limit_ms);

  assign closed_inc  = (closed_i == 16'hFFFF) ? closed_i : closed_i + 16'd1;
  assign fail_inc    = (fail_i == 8'hFF) ? fail_i : fail_i + 8'd1;
  assign closed_ms   = 32'(closed_inc) * 32'(cfg_i.scan_period_ms);
  assign shutter_hit = closed_ms > cfg_i.shutter_limit_ms;
  assign fail_hit    = fail_inc >= cfg_i.fail_limit;

  always_comb begin
    mode_o   = mode_i;
    timer_o  = idle_now;
    fail_o   = fail_i;
    closed_o = closed_i;
    lock     = 1'b0;
    case (mode_i)
      MODE_PRESENT: begin
        if (tick_i.activity_seen) begin
          timer_o = '0;
        end else if (over_inactive) begin
          mode_o = MODE_SCANNING;
          fail_o = '0;
        end
      end
      MODE_SCANNING: begin
        if (tick_i.activity_seen) begin
          mode_o   = MODE_PRESENT;
          timer_o  = '0;
          fail_o   = '0;
          closed_o = '0;
        end else if (!tick_i.face_seen && tick_i.shutter_closed) begin
          // closed shutter: skip failure and idle checks
          closed_o = closed_inc;
          if (shutter_hit) begin
            mode_o = MODE_AWAY;
            lock   = 1'b1;
          end
        end else begin
          closed_o = '0;
          if (tick_i.face_seen) begin
            mode_o  = MODE_PRESENT;
            timer_o = '0;
            fail_o  = '0;
          end else begin
            fail_o = fail_inc;
            if (fail_hit) begin
              mode_o = MODE_AWAY;
              lock   = 1'b1;
            end
          end
          // idle overrun wins even after a face
          if (over_idle) begin
            mode_o = MODE_AWAY;
            lock   = 1'b1;
          end
        end
      end
      default: begin
        if (tick_i.activity_seen) begin
          mode_o  = MODE_PRESENT;
          timer_o = '0;
        end
      end
    endcase
  end

  always_comb begin
    result_o.presence_mode   = mode_o;
    result_o.user_present    = (mode_o == MODE_PRESENT);
    result_o.lock_request    = lock;
    result_o.camera_release  = (mode_i == MODE_SCANNING) && (mode_o != MODE_SCANNING);
    result_o.failures_so_far = fail_o;
  end

endmodule

`default_nettype wire

>>> rtl/core/presence_lock_controller.sv
`default_nettype none

// Channel  | Handshake                     | Payload
// ---------+-------------------------------+------------------------------------------
// tick in  | in_valid_i / in_stall_o       | elapsed_ms_i, activity_seen_i, face_seen_i,
//          |                               | shutter_closed_i
// result   | out_valid_o / out_stall_i     | presence_mode_o, user_present_o,
//          |                               | lock_request_o, camera_release_o,
//          |                               | failures_so_far_o
// config   | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the result is not stalled.
// The item sits in an input register, one pass of compare and counter logic
// (a 16x16 multiply for the shutter duration) updates the state and fills the
// result register. Reset returns mode, timer and counters to zero and the
// limits to their defaults. A stalled result holds the input register, which
// then stalls the input.
module presence_lock_controller #(
  parameter int unsigned TimerWidth = plc_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [15:0]                         elapsed_ms_i,
  input  wire logic                                activity_seen_i,
  input  wire logic                                face_seen_i,
  input  wire logic                                shutter_closed_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [1:0]                               presence_mode_o,
  output logic                                     user_present_o,
  output logic                                     lock_request_o,
  output logic                                     camera_release_o,
  output logic [7:0]                               failures_so_far_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [plc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index_i,
  input  wire logic [plc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i
);
  import plc_pkg::*;

  cfg_t    cfg;
  tick_t   tick_q;
  logic    tick_valid_q;
  result_t res_q, res_d;
  logic    res_valid_q;
  logic    res_free;
  logic    advance;

  mode_e                 mode_q, mode_d;
  logic [TimerWidth-1:0] timer_q, timer_d;
  logic [7:0]            fail_q, fail_d;
  logic [15:0]           closed_q, closed_d;

  plc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  plc_step #(
    .TimerWidth (TimerWidth)
  ) u_step (
    .cfg_i    (cfg),
    .tick_i   (tick_q),
    .mode_i   (mode_q),
    .timer_i  (timer_q),
    .fail_i   (fail_q),
    .closed_i (closed_q),
    .mode_o   (mode_d),
    .timer_o  (timer_d),
    .fail_o   (fail_d),
    .closed_o (closed_d),
    .result_o (res_d)
  );

  assign res_free   = !res_valid_q || !out_stall_i;
  assign advance    = tick_valid_q && res_free;
  assign in_stall_o = tick_valid_q && !res_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      tick_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      tick_q.elapsed_ms     <= elapsed_ms_i;
      tick_q.activity_seen  <= activity_seen_i;
      tick_q.face_seen      <= face_seen_i;
      tick_q.shutter_closed <= shutter_closed_i;
    end
  end

  // state advances only when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PRESENT;
      timer_q  <= '0;
      fail_q   <= '0;
      closed_q <= '0;
    end else if (advance) begin
      mode_q   <= mode_d;
      timer_q  <= timer_d;
      fail_q   <= fail_d;
      closed_q <= closed_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= tick_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = res_valid_q;
  assign presence_mode_o   = res_q.presence_mode;
  assign user_present_o    = res_q.user_present;
  assign lock_request_o    = res_q.lock_request;
  assign camera_release_o  = res_q.camera_release;
  assign failures_so_far_o = res_q.failures_so_far;

endmodule

`default_nettype wire

>>> test/tb_presence_lock_controller.sv
`timescale 1ns / 1ps

module tb_presence_lock_controller;
  import plc_pkg::*;

  localparam int unsigned TIMER_W = 32;
  localparam int unsigned CYCLE_LIMIT = 5000000;
  localparam int unsigned RANDOM_SETS = 6;
  localparam int unsigned TICKS_PER_SET = 200;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNUSED_FIRST = 3'd5;
  localparam logic [31:0] SHUTTER_THIRD_SCAN_MS = 32'd196604;  // 3 * 65535 - 1

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] elapsed_ms_i = '0;
  logic activity_seen_i = 1'b0;
  logic face_seen_i = 1'b0;
  logic shutter_closed_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] presence_mode_o;
  logic user_present_o;
  logic lock_request_o;
  logic camera_release_o;
  logic [7:0] failures_so_far_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0] cfg_index_i = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data_i = '0;

  // predictor state and limits
  cfg_t limits = '{INACTIVE_LIMIT_RST, SCAN_PERIOD_RST, FAIL_LIMIT_RST,
                   IDLE_LIMIT_RST, SHUTTER_LIMIT_RST};
  mode_e cur_mode = MODE_PRESENT;
  logic [TIMER_W-1:0] idle_ms = '0;
  logic [7:0] fails = '0;
  logic [15:0] closed_scans = '0;

  result_t predicted_outcomes[$];
  int unsigned ticks_sent = 0;
  int unsigned results_checked = 0;
  int unsigned locks_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit no_idle = 1'b0;

  presence_lock_controller #(.TimerWidth(TIMER_W)) dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .elapsed_ms_i, .activity_seen_i, .face_seen_i, .shutter_closed_i,
    .out_valid_o, .out_stall_i,
    .presence_mode_o, .user_present_o, .lock_request_o, .camera_release_o,
    .failures_so_far_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_presence_lock_controller: done, errors");
      $finish;
    end
  end

  function automatic result_t advance_presence(input tick_t t);
    result_t r;
    mode_e was;
    logic lock;
    logic [TIMER_W:0] sum;
    logic [TIMER_W-1:0] idle_now;
    logic [31:0] shut_ms;
    was = cur_mode;
    lock = 1'b0;
    sum = {1'b0, idle_ms} + (TIMER_W+1)'(t.elapsed_ms);
    idle_ms = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
    idle_now = idle_ms;
    case (cur_mode)
      MODE_PRESENT: begin
        if (t.activity_seen) begin
          idle_ms = '0;
        end else if (idle_now > limits.inactive_limit_ms) begin
          cur_mode = MODE_SCANNING;
          fails = '0;
        end
      end
      MODE_SCANNING: begin
        if (t.activity_seen) begin
          cur_mode = MODE_PRESENT;
          idle_ms = '0;
          fails = '0;
          closed_scans = '0;
        end else if (!t.face_seen && t.shutter_closed) begin
          // closed frame: only the shutter duration is judged this tick
          if (closed_scans != 16'hFFFF) closed_scans++;
          shut_ms = 32'(closed_scans) * 32'(limits.scan_period_ms);
          if (shut_ms > limits.shutter_limit_ms) begin
            cur_mode = MODE_AWAY;
            lock = 1'b1;
          end
        end else begin
          closed_scans = '0;
          if (t.face_seen) begin
            cur_mode = MODE_PRESENT;
            idle_ms = '0;
            fails = '0;
          end else begin
            if (fails != 8'hFF) fails++;
            if (fails >= limits.fail_limit) begin
              cur_mode = MODE_AWAY;
              lock = 1'b1;
            end
          end
          // idle overrun wins even after a face in the same tick
          if (idle_now > limits.idle_limit_ms) begin
            cur_mode = MODE_AWAY;
            lock = 1'b1;
          end
        end
      end
      default: begin
        if (t.activity_seen) begin
          cur_mode = MODE_PRESENT;
          idle_ms = '0;
        end
      end
    endcase
    r.presence_mode = cur_mode;
    r.user_present = (cur_mode == MODE_PRESENT);
    r.lock_request = lock;
    r.camera_release = (was == MODE_SCANNING) && (cur_mode != MODE_SCANNING);
    r.failures_so_far = fails;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // check each accepted result, then draw the stall before the next one
  always @(posedge clk_i) begin : check_results
    result_t want;
    int unsigned hold;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      results_checked++;
      if (lock_request_o === 1'b1) locks_seen++;
      if (predicted_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: result with no tick pending, mode %0d", $time, presence_mode_o);
      end else begin
        want = predicted_outcomes.pop_front();
        check_field("presence_mode", 8'(want.presence_mode), 8'(presence_mode_o));
        check_field("user_present", 8'(want.user_present), 8'(user_present_o));
        check_field("lock_request", 8'(want.lock_request), 8'(lock_request_o));
        check_field("camera_release", 8'(want.camera_release), 8'(camera_release_o));
        check_field("failures_so_far", want.failures_so_far, failures_so_far_o);
      end
      hold = no_idle ? 0 : $urandom_range(0, 5);
      out_stall_i <= (hold != 0);
      stall_left <= hold;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall_i <= 1'b0;
    end
  end

  // valid stays high across back-to-back ticks; drop it only for a gap
  task automatic send_tick(input logic [15:0] elapsed, input logic act, input logic face,
                           input logic closed);
    tick_t t;
    int unsigned gap;
    t.elapsed_ms = elapsed;
    t.activity_seen = act;
    t.face_seen = face;
    t.shutter_closed = closed;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    elapsed_ms_i <= elapsed;
    activity_seen_i <= act;
    face_seen_i <= face;
    shutter_closed_i <= closed;
    do @(posedge clk_i); while (in_stall_o);
    predicted_outcomes.push_back(advance_presence(t));
    ticks_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (predicted_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_INACTIVE_LIMIT: limits.inactive_limit_ms = data;
      CFG_SCAN_PERIOD:    limits.scan_period_ms = data[15:0];
      CFG_FAIL_LIMIT:     limits.fail_limit = data[7:0];
      CFG_IDLE_LIMIT:     limits.idle_limit_ms = data;
      CFG_SHUTTER_LIMIT:  limits.shutter_limit_ms = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // walk every mode change under the reset limits
  task automatic test_reset_defaults();
    send_tick(16'd0, 1'b0, 1'b0, 1'b0);
    send_tick(16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_tick(16'd0, 1'b0, 1'b1, 1'b0);
    send_tick(16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0);
    send_tick(16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_tick(16'd0, 1'b0, 1'b0, 1'b1);
    send_tick(16'd0, 1'b0, 1'b1, 1'b1);
    send_tick(16'hFFFF, 1'b0, 1'b0, 1'b0);
    repeat (3) send_tick(16'd0, 1'b0, 1'b0, 1'b0);
    send_tick(16'd0, 1'b0, 1'b0, 1'b0);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_zero_limits();
    settle();
    write_reg(CFG_INACTIVE_LIMIT, 32'd0);
    write_reg(CFG_SCAN_PERIOD, 32'd0);
    write_reg(CFG_FAIL_LIMIT, 32'd0);
    write_reg(CFG_IDLE_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_SHUTTER_LIMIT, 32'd0);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0);
    send_tick(16'd0, 1'b0, 1'b0, 1'b0);
    send_tick(16'd1, 1'b0, 1'b0, 1'b0);
    // zero scan period never trips the shutter lock
    send_tick(16'hFFFF, 1'b0, 1'b0, 1'b1);
    // zero fail limit locks on the first failed scan
    send_tick(16'd0, 1'b0, 1'b0, 1'b0);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0);
    settle();
    write_reg(CFG_IDLE_LIMIT, 32'd0);
    write_reg(CFG_SCAN_PERIOD, 32'd1);
    for (int i = CFG_UNUSED_FIRST; i < 8; i++) write_reg(i[CFG_IDX_WIDTH-1:0], 32'hFFFF_FFFF);
    send_tick(16'd1, 1'b0, 1'b0, 1'b0);
    // face seen, but the idle overrun still locks
    send_tick(16'd0, 1'b0, 1'b1, 1'b0);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0);
    send_tick(16'd1, 1'b0, 1'b0, 1'b0);
    send_tick(16'hFFFF, 1'b0, 1'b0, 1'b1);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_saturation();
    settle();
    no_idle = 1'b1;
    write_reg(CFG_INACTIVE_LIMIT, 32'd0);
    write_reg(CFG_IDLE_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_SHUTTER_LIMIT, SHUTTER_THIRD_SCAN_MS);
    write_reg(CFG_SCAN_PERIOD, 32'h0000_FFFF);
    write_reg(CFG_FAIL_LIMIT, 32'h0000_00FF);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0);
    send_tick(16'd1, 1'b0, 1'b0, 1'b0);
    // longest scan period: the third closed scan crosses the shutter limit
    repeat (3) send_tick(16'd0, 1'b0, 1'b0, 1'b1);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0);
    send_tick(16'd1, 1'b0, 1'b0, 1'b0);
    // drive the fail count up to its ceiling
    repeat (255) send_tick(16'd0, 1'b0, 1'b0, 1'b0);
    send_tick(16'd0, 1'b0, 1'b0, 1'b0);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0);
    no_idle = 1'b0;
  endtask

  function automatic logic [31:0] pick_limit(input int unsigned typical_max);
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, typical_max);
    endcase
  endfunction

  task automatic test_random_sets();
    logic [15:0] period;
    logic [7:0] fail_lim;
    logic [15:0] elapsed;
    for (int s = 0; s < RANDOM_SETS; s++) begin
      settle();
      case ($urandom_range(0, 4))
        0: period = 16'd0;
        1: period = 16'hFFFF;
        default: period = 16'($urandom_range(1, 3000));
      endcase
      case ($urandom_range(0, 4))
        0: fail_lim = 8'd0;
        1: fail_lim = 8'hFF;
        default: fail_lim = 8'($urandom_range(1, 6));
      endcase
      write_reg(CFG_INACTIVE_LIMIT, pick_limit(8000));
      // junk above the register width must be dropped
      write_reg(CFG_SCAN_PERIOD, {16'($urandom), period});
      write_reg(CFG_FAIL_LIMIT, {24'($urandom), fail_lim});
      write_reg(CFG_IDLE_LIMIT, pick_limit(40000));
      write_reg(CFG_SHUTTER_LIMIT, pick_limit(20000));
      if ($urandom_range(0, 1) == 0)
        write_reg(CFG_IDX_WIDTH'($urandom_range(CFG_UNUSED_FIRST, 7)), $urandom);
      no_idle = (s == 2);
      repeat (TICKS_PER_SET) begin
        case ($urandom_range(0, 9))
          0: elapsed = 16'($urandom_range(0, 65535));
          1: elapsed = 16'd0;
          2: elapsed = 16'hFFFF;
          default: elapsed = 16'($urandom_range(0, 3000));
        endcase
        send_tick(elapsed, $urandom_range(0, 9) == 0, $urandom_range(0, 4) == 0,
                  $urandom_range(0, 2) == 0);
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_zero_limits();
    test_saturation();
    test_random_sets();
    settle();
    repeat (8) @(posedge clk_i);
    $display("ran %0d ticks: reset limits, zero limits, shutter edge, fail ceiling, %0d random sets",
             ticks_sent, RANDOM_SETS);
    $display("checked %0d results, %0d lock requests, %0d mismatches",
             results_checked, locks_seen, mismatches);
    if (mismatches == 0 && predicted_outcomes.size() == 0) begin
      $display("tb_presence_lock_controller: done, clean");
    end else begin
      $display("tb_presence_lock_controller: done, errors");
    end
    $finish;
  end

endmodule
